>>> design/owbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the one-wire bus master
// Phase codes, command codes, register indexes, reset values and the CRC-8 step.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int PHASE_W = 3;
   localparam int TICK_W  = 10;
   localparam int ATT_W   = 6;
   localparam int BIT_W   = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [PHASE_W-1:0] PH_IDLE          = 3'd0;
   localparam logic [PHASE_W-1:0] PH_RST_LOW       = 3'd1;
   localparam logic [PHASE_W-1:0] PH_RST_WAIT_HIGH = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RST_WINDOW    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_WRITE         = 3'd4;
   localparam logic [PHASE_W-1:0] PH_READ          = 3'd5;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_RESET = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WR_ONE_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WR_ZERO_LOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RD_SAMPLE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTEMPTS    = 3'd6;

   localparam logic [TICK_W-1:0] RESET_LOW_RST   = 10'd150;
   localparam logic [TICK_W-1:0] PRES_WINDOW_RST = 10'd300;
   localparam logic [TICK_W-1:0] SLOT_RST        = 10'd40;
   localparam logic [TICK_W-1:0] WR_ONE_LOW_RST  = 10'd3;
   localparam logic [TICK_W-1:0] WR_ZERO_LOW_RST = 10'd19;
   localparam logic [TICK_W-1:0] RD_SAMPLE_RST   = 10'd3;
   localparam logic [ATT_W-1:0]  ATTEMPTS_RST    = 6'd50;

   localparam logic [TICK_W-1:0] TICK_MAX = 10'h3FF;
   localparam logic [7:0]        CRC_POLY = 8'h8C;

   typedef struct packed {
      logic [TICK_W-1:0] reset_low_ticks;
      logic [TICK_W-1:0] presence_window_ticks;
      logic [TICK_W-1:0] slot_ticks;
      logic [TICK_W-1:0] write_one_low_ticks;
      logic [TICK_W-1:0] write_zero_low_ticks;
      logic [TICK_W-1:0] read_sample_tick;
      logic [ATT_W-1:0]  reset_attempts;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TICK_W-1:0]  tick_count;
      logic [BIT_W-1:0]   bit_index;
      logic [7:0]         shift_byte;
      logic [7:0]         crc_reg;
      logic [ATT_W-1:0]   attempt_count;
      logic               presence_flag;
      logic               crc_enable;
      logic [7:0]         rx_last;
   } state_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] rx_byte;
      logic [7:0] crc_value;
   } res_type;

   function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
      logic [7:0] shifted;
      shifted = {1'b0, crc[7:1]};
      return (crc[0] ^ b) ? (shifted ^ CRC_POLY) : shifted;
   endfunction

endpackage

>>> design/owbm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_if: channel interfaces of the one-wire bus master
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] tx_byte;
   logic       update_crc;
   logic       line_level;

   modport source (output valid, req_type, tx_byte, update_crc, line_level,
                   input ready);
   modport sink   (input valid, req_type, tx_byte, update_crc, line_level,
                   output ready);
endinterface

interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] rx_byte;
   logic [7:0] crc_value;

   modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte,
                   crc_value, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte,
                   crc_value, output ready);
endinterface

interface owbm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/owbm_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_csr: timing register file
// Holds the slot, reset, presence, write-low and read-sample timing and the attempt limit.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  logic               clock,
   input  logic               reset,
   owbm_csr_if.sink           csr_if,
   output owbm_pkg::cfg_type  cfg
);

   owbm_pkg::cfg_type cfg_ff;
   owbm_pkg::cfg_type cfg_in;
   logic              csr_accept;

   assign csr_if.ready = 1'b1;
   assign csr_accept   = csr_if.valid && csr_if.ready;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_accept) begin
         unique case (csr_if.index)
            owbm_pkg::CSR_RESET_LOW:   cfg_in.reset_low_ticks       = csr_if.data;
            owbm_pkg::CSR_PRES_WINDOW: cfg_in.presence_window_ticks = csr_if.data;
            owbm_pkg::CSR_SLOT:        cfg_in.slot_ticks            = csr_if.data;
            owbm_pkg::CSR_WR_ONE_LOW:  cfg_in.write_one_low_ticks   = csr_if.data;
            owbm_pkg::CSR_WR_ZERO_LOW: cfg_in.write_zero_low_ticks  = csr_if.data;
            owbm_pkg::CSR_RD_SAMPLE:   cfg_in.read_sample_tick      = csr_if.data;
            owbm_pkg::CSR_ATTEMPTS:
               cfg_in.reset_attempts = csr_if.data[owbm_pkg::ATT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= owbm_pkg::RESET_LOW_RST;
         cfg_ff.presence_window_ticks <= owbm_pkg::PRES_WINDOW_RST;
         cfg_ff.slot_ticks            <= owbm_pkg::SLOT_RST;
         cfg_ff.write_one_low_ticks   <= owbm_pkg::WR_ONE_LOW_RST;
         cfg_ff.write_zero_low_ticks  <= owbm_pkg::WR_ZERO_LOW_RST;
         cfg_ff.read_sample_tick      <= owbm_pkg::RD_SAMPLE_RST;
         cfg_ff.reset_attempts        <= owbm_pkg::ATTEMPTS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/owbm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_step: one bus tick of the master sequencer
// Computes the next sequencer state and the tick's outputs from the request.
// ----------------------------------------------------------------------------
module owbm_step (
   input  owbm_pkg::cfg_type    cfg,
   input  owbm_pkg::state_type  cur,
   input  logic [1:0]           req_type,
   input  logic [7:0]           tx_byte,
   input  logic                 update_crc,
   input  logic                 line_level,
   output owbm_pkg::state_type  nxt,
   output owbm_pkg::res_type    res
);

   logic [owbm_pkg::TICK_W:0]   tick_inc;
   logic [owbm_pkg::TICK_W-1:0] low_ticks;
   logic [owbm_pkg::ATT_W-1:0]  att_inc;
   logic                        drive;
   logic                        done;
   logic                        last;
   logic                        sample;
   logic                        rd_bit;

   always_comb begin
      nxt       = cur;
      drive     = 1'b0;
      done      = 1'b0;
      tick_inc  = '0;
      low_ticks = '0;
      att_inc   = '0;
      last      = 1'b0;
      sample    = 1'b0;
      rd_bit    = 1'b0;

      if (cur.phase == owbm_pkg::PH_IDLE) begin
         nxt.tick_count = '0;
         nxt.bit_index  = '0;
         unique case (req_type)
            owbm_pkg::REQ_RESET: begin
               nxt.phase         = owbm_pkg::PH_RST_LOW;
               nxt.attempt_count = '0;
               nxt.presence_flag = 1'b0;
            end
            owbm_pkg::REQ_WRITE: begin
               nxt.phase      = owbm_pkg::PH_WRITE;
               nxt.shift_byte = tx_byte;
            end
            owbm_pkg::REQ_READ: begin
               nxt.phase      = owbm_pkg::PH_READ;
               nxt.shift_byte = '0;
               nxt.crc_enable = update_crc;
            end
            default: ;
         endcase
      end

      tick_inc = {1'b0, nxt.tick_count} + 1'b1;

      unique case (nxt.phase)
         owbm_pkg::PH_IDLE: ;
         owbm_pkg::PH_RST_LOW: begin
            drive          = 1'b1;
            nxt.tick_count = tick_inc[owbm_pkg::TICK_W-1:0];
            if (nxt.tick_count >= cfg.reset_low_ticks) begin
               nxt.phase      = owbm_pkg::PH_RST_WAIT_HIGH;
               nxt.tick_count = '0;
            end
         end
         owbm_pkg::PH_RST_WAIT_HIGH: begin
            if (nxt.tick_count != owbm_pkg::TICK_MAX) begin
               nxt.tick_count = tick_inc[owbm_pkg::TICK_W-1:0];
            end
            if (line_level) begin
               nxt.phase = owbm_pkg::PH_RST_WINDOW;
            end
         end
         owbm_pkg::PH_RST_WINDOW: begin
            if (nxt.tick_count < cfg.presence_window_ticks) begin
               if (!line_level) begin
                  nxt.presence_flag = 1'b1;
               end
               nxt.tick_count = tick_inc[owbm_pkg::TICK_W-1:0];
            end
            if (tick_inc >= {1'b0, cfg.presence_window_ticks}) begin
               att_inc = nxt.attempt_count + 1'b1;
               if (nxt.presence_flag) begin
                  nxt.phase = owbm_pkg::PH_IDLE;
                  done      = 1'b1;
               end else begin
                  nxt.attempt_count = att_inc;
                  if (att_inc >= cfg.reset_attempts) begin
                     nxt.phase = owbm_pkg::PH_IDLE;
                     done      = 1'b1;
                  end else begin
                     nxt.phase      = owbm_pkg::PH_RST_LOW;
                     nxt.tick_count = '0;
                  end
               end
            end
         end
         owbm_pkg::PH_WRITE: begin
            low_ticks      = nxt.shift_byte[0] ? cfg.write_one_low_ticks
                                               : cfg.write_zero_low_ticks;
            drive          = nxt.tick_count < low_ticks;
            nxt.tick_count = tick_inc[owbm_pkg::TICK_W-1:0];
            if (nxt.tick_count >= cfg.slot_ticks) begin
               nxt.tick_count = '0;
               nxt.shift_byte = {1'b0, nxt.shift_byte[7:1]};
               if (nxt.bit_index == 3'd7) begin
                  nxt.phase = owbm_pkg::PH_IDLE;
                  done      = 1'b1;
               end else begin
                  nxt.bit_index = nxt.bit_index + 1'b1;
               end
            end
         end
         owbm_pkg::PH_READ: begin
            last   = tick_inc >= {1'b0, cfg.slot_ticks};
            drive  = nxt.tick_count < cfg.read_sample_tick;
            sample = (nxt.tick_count == cfg.read_sample_tick) || (last && drive);
            rd_bit = !drive && line_level;
            if (sample) begin
               nxt.shift_byte = {rd_bit, nxt.shift_byte[7:1]};
               if (nxt.crc_enable) begin
                  nxt.crc_reg = owbm_pkg::crc_bit(nxt.crc_reg, rd_bit);
               end
            end
            nxt.tick_count = tick_inc[owbm_pkg::TICK_W-1:0];
            if (last) begin
               nxt.tick_count = '0;
               if (nxt.bit_index == 3'd7) begin
                  nxt.rx_last = nxt.shift_byte;
                  nxt.phase   = owbm_pkg::PH_IDLE;
                  done        = 1'b1;
               end else begin
                  nxt.bit_index = nxt.bit_index + 1'b1;
               end
            end
         end
         default: nxt.phase = owbm_pkg::PH_IDLE;
      endcase

      res.drive_low = drive;
      res.busy_res  = nxt.phase != owbm_pkg::PH_IDLE;
      res.done_res  = done;
      res.presence  = nxt.presence_flag;
      res.rx_byte   = nxt.rx_last;
      res.crc_value = nxt.crc_reg;
   end

endmodule

>>> design/one_wire_bus_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit: one-wire bus master, one bus tick per transaction
// Reset with presence detect, byte write and byte read with Dallas CRC-8.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req_if   in   req_type, tx_byte, update_crc, line_level
// rsp_if   out  drive_low, busy_res, done_res, presence, rx_byte, crc_value
// csr_if   in   index, data (timing registers, always ready)
//
// One transaction per clock while responses are taken; its response is registered
// and appears the next cycle; the tick sequencer feeds the response register.
// A stalled response holds the request side only while it is still pending.
// Reset clears the sequencer to idle and loads the default timing registers.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit (
   input  logic        clock,
   input  logic        reset,
   owbm_req_if.sink    req_if,
   owbm_rsp_if.source  rsp_if,
   owbm_csr_if.sink    csr_if
);

   owbm_pkg::cfg_type   cfg;
   owbm_pkg::state_type state_ff;
   owbm_pkg::state_type state_in;
   owbm_pkg::state_type step_state;
   owbm_pkg::res_type   step_res;
   owbm_pkg::res_type   rsp_ff;
   owbm_pkg::res_type   rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                req_accept;

   owbm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   owbm_step u_step (
      .cfg        (cfg),
      .cur        (state_ff),
      .req_type   (req_if.req_type),
      .tx_byte    (req_if.tx_byte),
      .update_crc (req_if.update_crc),
      .line_level (req_if.line_level),
      .nxt        (step_state),
      .res        (step_res)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      state_in     = req_accept ? step_state : state_ff;
      rsp_in       = req_accept ? step_res : rsp_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.drive_low = rsp_ff.drive_low;
   assign rsp_if.busy_res  = rsp_ff.busy_res;
   assign rsp_if.done_res  = rsp_ff.done_res;
   assign rsp_if.presence  = rsp_ff.presence;
   assign rsp_if.rx_byte   = rsp_ff.rx_byte;
   assign rsp_if.crc_value = rsp_ff.crc_value;

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("command reported done while still busy");

   a_drive_in_command : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drive_low |-> rsp_ff.busy_res || rsp_ff.done_res)
      else $error("bus driven low outside a command");

   a_command_starts : assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.phase == owbm_pkg::PH_IDLE
      && req_if.req_type != owbm_pkg::REQ_TICK
      |=> state_ff.phase != owbm_pkg::PH_IDLE)
      else $error("accepted command did not leave idle");

   a_busy_tracks_phase : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_ff.busy_res == (state_ff.phase != owbm_pkg::PH_IDLE))
      else $error("busy flag disagrees with sequencer phase");

endmodule

>>> sim/one_wire_bus_master_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit_test: self-checking bench for the one-wire master
// Drives one bus tick per transaction. A short stimulus table comes first,
// then randomised command traffic over several timing settings, including
// all-zero, all-one, maximum low and sample times, and reset values. A
// tick-accurate sequencer model predicts all responses but the first
// three table rows, which hold fixed ones. Both channels idle at random.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit_test;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] tx_byte;
      logic       update_crc;
      logic       line_level;
   } bus_tick_type;

   typedef struct {
      bus_tick_type      item;
      bit                typed;
      owbm_pkg::res_type want;
   } stim_row_type;

   typedef enum {CFG_SMALL, CFG_ZERO, CFG_ONE, CFG_MAX, CFG_DEFAULT, CFG_TRIES} cfg_kind_type;

   localparam owbm_pkg::cfg_type BOOT_CFG = '{owbm_pkg::RESET_LOW_RST,
                                              owbm_pkg::PRES_WINDOW_RST,
                                              owbm_pkg::SLOT_RST,
                                              owbm_pkg::WR_ONE_LOW_RST,
                                              owbm_pkg::WR_ZERO_LOW_RST,
                                              owbm_pkg::RD_SAMPLE_RST,
                                              owbm_pkg::ATTEMPTS_RST};
   localparam owbm_pkg::cfg_type TABLE_CFG = '{10'd1, 10'd2, 10'd1, 10'd1, 10'd0, 10'd0,
                                               6'd1};
   localparam owbm_pkg::res_type QUIET = '0;
   localparam owbm_pkg::res_type RESET_START = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00};

   logic clock;
   logic reset;

   owbm_req_if req_if ();
   owbm_rsp_if rsp_if ();
   owbm_csr_if csr_if ();

   one_wire_bus_master_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // sequencer model
   owbm_pkg::cfg_type           m_cfg    = BOOT_CFG;
   logic [owbm_pkg::PHASE_W-1:0] m_phase = owbm_pkg::PH_IDLE;
   int               m_ticks  = 0;
   int               m_bit    = 0;
   int               m_tries  = 0;
   logic [7:0]       m_shift  = '0;
   logic [7:0]       m_crc    = '0;
   logic [7:0]       m_rx     = '0;
   logic             m_pres   = 1'b0;
   logic             m_crc_en = 1'b0;

   owbm_pkg::res_type results_due [$];
   stim_row_type      stim_rows [$];
   int        mismatches = 0;
   int        hold_low   = 0;
   bit        calm       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("** one_wire_bus_master_unit: FAILED **");
      $finish;
   end

   function automatic int pick_gap();
      if (calm) return 0;
      case ($urandom_range(0, 15))
         0, 1, 2, 3: return $urandom_range(1, 3);
         4:          return $urandom_range(8, 30);
         default:    return 0;
      endcase
   endfunction

   function automatic bit close_attempt();
      if (m_pres) begin
         m_phase = owbm_pkg::PH_IDLE;
         return 1'b1;
      end
      m_tries = (m_tries + 1) & 63;
      if (m_tries >= m_cfg.reset_attempts) begin
         m_phase = owbm_pkg::PH_IDLE;
         return 1'b1;
      end
      m_phase = owbm_pkg::PH_RST_LOW;
      m_ticks = 0;
      return 1'b0;
   endfunction

   task automatic master_tick(input bus_tick_type t, output owbm_pkg::res_type r);
      logic                        drive;
      logic                        done;
      logic                        slot_end;
      logic                        bit_in;
      logic [owbm_pkg::TICK_W-1:0] low_len;
      drive = 1'b0;
      done  = 1'b0;
      if (m_phase == owbm_pkg::PH_IDLE) begin
         m_ticks = 0;
         m_bit   = 0;
         case (t.req_type)
            owbm_pkg::REQ_RESET: begin
               m_phase = owbm_pkg::PH_RST_LOW;
               m_tries = 0;
               m_pres  = 1'b0;
            end
            owbm_pkg::REQ_WRITE: begin
               m_phase = owbm_pkg::PH_WRITE;
               m_shift = t.tx_byte;
            end
            owbm_pkg::REQ_READ: begin
               m_phase  = owbm_pkg::PH_READ;
               m_shift  = '0;
               m_crc_en = t.update_crc;
            end
            default: ;
         endcase
      end
      case (m_phase)
         owbm_pkg::PH_IDLE: ;
         owbm_pkg::PH_RST_LOW: begin
            drive   = 1'b1;
            m_ticks = (m_ticks + 1) & owbm_pkg::TICK_MAX;
            if (m_ticks >= m_cfg.reset_low_ticks) begin
               m_phase = owbm_pkg::PH_RST_WAIT_HIGH;
               m_ticks = 0;
            end
         end
         owbm_pkg::PH_RST_WAIT_HIGH: begin
            if (m_ticks < owbm_pkg::TICK_MAX) m_ticks++;
            if (t.line_level) m_phase = owbm_pkg::PH_RST_WINDOW;
         end
         owbm_pkg::PH_RST_WINDOW: begin
            if (m_ticks >= m_cfg.presence_window_ticks) begin
               done = close_attempt();
            end else begin
               if (!t.line_level) m_pres = 1'b1;
               m_ticks++;
               if (m_ticks >= m_cfg.presence_window_ticks) done = close_attempt();
            end
         end
         owbm_pkg::PH_WRITE: begin
            low_len = m_shift[0] ? m_cfg.write_one_low_ticks : m_cfg.write_zero_low_ticks;
            drive   = (m_ticks < low_len);
            m_ticks = (m_ticks + 1) & owbm_pkg::TICK_MAX;
            if (m_ticks >= m_cfg.slot_ticks) begin
               m_ticks = 0;
               m_shift = m_shift >> 1;
               if (m_bit >= 7) begin
                  m_phase = owbm_pkg::PH_IDLE;
                  done    = 1'b1;
               end else begin
                  m_bit++;
               end
            end
         end
         owbm_pkg::PH_READ: begin
            slot_end = ((m_ticks + 1) >= m_cfg.slot_ticks);
            drive    = (m_ticks < m_cfg.read_sample_tick);
            if (m_ticks == m_cfg.read_sample_tick ||
                (slot_end && m_cfg.read_sample_tick > m_ticks)) begin
               bit_in  = drive ? 1'b0 : t.line_level;
               m_shift = {bit_in, m_shift[7:1]};
               if (m_crc_en)
                  m_crc = {1'b0, m_crc[7:1]} ^
                          ((m_crc[0] ^ bit_in) ? owbm_pkg::CRC_POLY : 8'h00);
            end
            m_ticks = (m_ticks + 1) & owbm_pkg::TICK_MAX;
            if (slot_end) begin
               m_ticks = 0;
               if (m_bit >= 7) begin
                  m_rx    = m_shift;
                  m_phase = owbm_pkg::PH_IDLE;
                  done    = 1'b1;
               end else begin
                  m_bit++;
               end
            end
         end
         default: m_phase = owbm_pkg::PH_IDLE;
      endcase
      r.drive_low = drive;
      r.busy_res  = (m_phase != owbm_pkg::PH_IDLE);
      r.done_res  = done;
      r.presence  = m_pres;
      r.rx_byte   = m_rx;
      r.crc_value = m_crc;
   endtask

   function automatic stim_row_type stim_row(input logic [1:0] rq, input logic [7:0] tx,
                                             input bit upd, input bit ln,
                                             input bit typed = 1'b0,
                                             input owbm_pkg::res_type want = '0);
      stim_row_type s;
      s.item  = '{rq, tx, upd, ln};
      s.typed = typed;
      s.want  = want;
      return s;
   endfunction

   task automatic send_tick(input bus_tick_type t, input bit typed,
                            input owbm_pkg::res_type want);
      owbm_pkg::res_type r;
      int                gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= t.req_type;
      req_if.tx_byte    <= t.tx_byte;
      req_if.update_crc <= t.update_crc;
      req_if.line_level <= t.line_level;
      do @(posedge clock); while (!req_if.ready);
      master_tick(t, r);
      results_due.push_back(typed ? want : r);
   endtask

   task automatic program_regs(input owbm_pkg::cfg_type c);
      logic [owbm_pkg::CSR_IDX_W-1:0] idx [7];
      logic [owbm_pkg::TICK_W-1:0]    val [7];
      idx = '{owbm_pkg::CSR_RESET_LOW, owbm_pkg::CSR_PRES_WINDOW, owbm_pkg::CSR_SLOT,
              owbm_pkg::CSR_WR_ONE_LOW, owbm_pkg::CSR_WR_ZERO_LOW,
              owbm_pkg::CSR_RD_SAMPLE, owbm_pkg::CSR_ATTEMPTS};
      val = '{c.reset_low_ticks, c.presence_window_ticks, c.slot_ticks,
              c.write_one_low_ticks, c.write_zero_low_ticks, c.read_sample_tick,
              10'(c.reset_attempts)};
      for (int k = 0; k < 7; k++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx[k];
         csr_if.data  <= val[k];
         do @(posedge clock); while (!csr_if.ready);
      end
      m_cfg = c;
      csr_if.valid <= 1'b0;
   endtask

   task automatic settle();
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input cfg_kind_type kind, input int budget,
                            input logic [1:0] only_cmd, input bit device, input bit quiet);
      owbm_pkg::cfg_type c;
      bus_tick_type      t;
      int                n;
      case (kind)
         CFG_ZERO:    c = '0;
         CFG_ONE:     c = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 6'd1};
         CFG_MAX: begin
            c                       = '1;
            c.slot_ticks            = 10'($urandom_range(1, 10));
            c.reset_low_ticks       = 10'($urandom_range(1, 6));
            c.presence_window_ticks = 10'($urandom_range(1, 10));
         end
         CFG_DEFAULT: c = BOOT_CFG;
         default: begin
            c.slot_ticks            = 10'($urandom_range(1, 10));
            c.reset_low_ticks       = 10'($urandom_range(1, 6));
            c.presence_window_ticks = 10'($urandom_range(1, 10));
            c.write_one_low_ticks   = 10'($urandom_range(0, c.slot_ticks + 1));
            c.write_zero_low_ticks  = 10'($urandom_range(0, c.slot_ticks + 1));
            c.read_sample_tick      = 10'($urandom_range(0, c.slot_ticks + 1));
            c.reset_attempts        = 6'($urandom_range(1, 6));
            if (kind == CFG_TRIES) begin
               c.reset_low_ticks       = 10'($urandom_range(1, 3));
               c.presence_window_ticks = 10'($urandom_range(1, 4));
               c.reset_attempts        = 6'd63;
            end
         end
      endcase
      program_regs(c);
      calm = quiet;
      n = 0;
      while (n < budget || m_phase != owbm_pkg::PH_IDLE) begin
         t.req_type   = owbm_pkg::REQ_TICK;
         t.tx_byte    = ($urandom_range(0, 7) == 0) ?
                        ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
         t.update_crc = 1'($urandom_range(0, 1));
         t.line_level = 1'($urandom_range(0, 1));
         if (m_phase == owbm_pkg::PH_IDLE) begin
            if (n < budget && $urandom_range(0, 3) != 0) begin
               t.req_type = (only_cmd == owbm_pkg::REQ_TICK) ?
                            2'($urandom_range(1, 3)) : only_cmd;
               if (t.req_type == owbm_pkg::REQ_RESET)
                  hold_low = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40) : 0;
            end
         end else begin
            if (n < budget && $urandom_range(0, 7) == 0) t.req_type = 2'($urandom_range(0, 3));
            if (m_phase == owbm_pkg::PH_RST_WAIT_HIGH && hold_low > 0) begin
               t.line_level = 1'b0;
               hold_low--;
            end else if (m_phase == owbm_pkg::PH_RST_WINDOW) begin
               t.line_level = device ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
         end
         send_tick(t, 1'b0, QUIET);
         n++;
      end
      req_if.valid <= 1'b0;
      calm = 1'b0;
      settle();
   endtask

   // response side: check and stall
   initial begin : rsp_side
      owbm_pkg::res_type want;
      int                stall;
      rsp_if.ready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (results_due.size() == 0) begin
               $error("response with no transaction pending");
               mismatches++;
            end else begin
               want = results_due.pop_front();
               if (rsp_if.drive_low !== want.drive_low) begin
                  $error("drive_low: expected %0d, got %0d", want.drive_low, rsp_if.drive_low);
                  mismatches++;
               end
               if (rsp_if.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_if.busy_res);
                  mismatches++;
               end
               if (rsp_if.done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res, rsp_if.done_res);
                  mismatches++;
               end
               if (rsp_if.presence !== want.presence) begin
                  $error("presence: expected %0d, got %0d", want.presence, rsp_if.presence);
                  mismatches++;
               end
               if (rsp_if.rx_byte !== want.rx_byte) begin
                  $error("rx_byte: expected %02h, got %02h", want.rx_byte, rsp_if.rx_byte);
                  mismatches++;
               end
               if (rsp_if.crc_value !== want.crc_value) begin
                  $error("crc_value: expected %02h, got %02h", want.crc_value,
                         rsp_if.crc_value);
                  mismatches++;
               end
            end
         end
         if (stall > 0) stall--;
         else stall = pick_gap();
         rsp_if.ready <= (stall == 0);
      end
   end

   // request side
   initial begin : req_side
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.req_type   = owbm_pkg::REQ_TICK;
      req_if.tx_byte    = '0;
      req_if.update_crc = 1'b0;
      req_if.line_level = 1'b1;
      csr_if.valid      = 1'b0;
      csr_if.index      = owbm_pkg::CSR_RESET_LOW;
      csr_if.data       = '0;

      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1, QUIET));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'hFF, 1'b1, 1'b0, 1'b1, QUIET));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_RESET, 8'h00, 1'b0, 1'b1, 1'b1,
                                   RESET_START));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_WRITE, 8'hA5, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_READ,  8'h00, 1'b1, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_RESET, 8'hFF, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_WRITE, 8'h00, 1'b1, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_READ,  8'h00, 1'b1, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      // line held low after release, then high too late for the window
      stim_rows.push_back(stim_row(owbm_pkg::REQ_RESET, 8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));
      stim_rows.push_back(stim_row(owbm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      program_regs(TABLE_CFG);
      foreach (stim_rows[i]) send_tick(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
      req_if.valid <= 1'b0;
      settle();

      run_phase(CFG_SMALL,   200, owbm_pkg::REQ_TICK,  1'b1, 1'b0);
      run_phase(CFG_ZERO,    100, owbm_pkg::REQ_TICK,  1'b1, 1'b0);
      run_phase(CFG_SMALL,   200, owbm_pkg::REQ_TICK,  1'b1, 1'b1);
      run_phase(CFG_TRIES,   100, owbm_pkg::REQ_RESET, 1'b0, 1'b0);
      run_phase(CFG_ONE,     100, owbm_pkg::REQ_TICK,  1'b1, 1'b0);
      run_phase(CFG_DEFAULT, 150, owbm_pkg::REQ_TICK,  1'b1, 1'b0);
      run_phase(CFG_MAX,      20, owbm_pkg::REQ_RESET, 1'b1, 1'b0);
      run_phase(CFG_MAX,      20, owbm_pkg::REQ_WRITE, 1'b1, 1'b0);
      run_phase(CFG_MAX,      20, owbm_pkg::REQ_READ,  1'b1, 1'b0);
      run_phase(CFG_SMALL,   200, owbm_pkg::REQ_TICK,  1'b0, 1'b0);
      run_phase(CFG_SMALL,   200, owbm_pkg::REQ_TICK,  1'b1, 1'b0);

      if (mismatches == 0) begin
         $display("** one_wire_bus_master_unit: PASSED **");
      end else begin
         $display("** one_wire_bus_master_unit: FAILED **");
      end
      $finish;
   end

endmodule
